// ----- hw/rtl/weighted_run_queue_sort_core_defines.svh -----
// ----------------------------------------------------------------------------
// Weighted run queue sort core: assertion macros
// Shared shorthands for concurrent checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RUN_QUEUE_SORT_CORE_DEFINES_SVH
`define WEIGHTED_RUN_QUEUE_SORT_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define WRQS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that cons holds in the cycle after ante.
`define WRQS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- hw/rtl/wrqs_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted run queue sort: package
// Sizes, field types, operation and status codes, and controller commands.
// ----------------------------------------------------------------------------
package wrqs_pkg;

  // Queue depth and derived widths
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PASS_W  = $clog2(DEPTH);
  localparam int COUNT_W = 5;
  localparam int ID_W    = 8;
  localparam int WT_W    = 16;
  localparam int OP_W    = 2;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [PASS_W-1:0]  pass_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [WT_W-1:0]    wt_t;

  localparam cnt_t  CNT_FULL  = cnt_t'(DEPTH);
  localparam pass_t LAST_PASS = pass_t'(DEPTH - 1);

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SORT    = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic exec;       // run enqueue, dequeue or no-op and load its result
    logic pass_en;    // run one odd-even transposition pass
    logic pass_odd;   // pass works on pairs starting at odd positions
    logic sort_done;  // load the result of a finished sort
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_lt2;  // fewer than two entries, nothing to sort
  } stat_t;

endpackage

// ----- hw/rtl/wrqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Weighted run queue sort: controller
// Request handshake, sort pass sequencing and result valid tracking.
// ----------------------------------------------------------------------------
module wrqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wrqs_pkg::stat_t   stat_i,
  output wrqs_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SORT = 2'b10
  } state_e;

  state_e          state_q, state_d;
  wrqs_pkg::pass_t pass_q, pass_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  // Take a request only when idle and the result slot is free or draining
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Sequence requests and sort passes
  always_comb begin
    state_d          = state_q;
    pass_d           = pass_q;
    cmd_o            = '0;
    cmd_o.pass_odd   = pass_q[0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == wrqs_pkg::OP_SORT) begin
            if (stat_i.count_lt2) begin
              cmd_o.sort_done = 1'b1;
            end else begin
              state_d = S_SORT;
              pass_d  = '0;
            end
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      S_SORT: begin
        cmd_o.pass_en = 1'b1;
        pass_d        = pass_q + 1'b1;
        if (pass_q == wrqs_pkg::LAST_PASS) begin
          cmd_o.sort_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Drop the result when taken, raise it when a new one loads
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.exec || cmd_o.sort_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/wrqs_dp.sv -----
// ----------------------------------------------------------------------------
// Weighted run queue sort: datapath
// Entry shift line, compare-swap network for one transposition pass, and
// the result register.
// ----------------------------------------------------------------------------
module wrqs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wrqs_pkg::cmd_t    cmd_i,
  output wrqs_pkg::stat_t   stat_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        thread_id_i,
  input  logic [15:0]       weight_i,
  output logic [1:0]        status_o,
  output logic [7:0]        out_thread_id_o,
  output logic [15:0]       out_weight_o,
  output logic [4:0]        count_o
);

  wrqs_pkg::id_t   ids_q [wrqs_pkg::DEPTH];
  wrqs_pkg::id_t   ids_d [wrqs_pkg::DEPTH];
  wrqs_pkg::wt_t   wts_q [wrqs_pkg::DEPTH];
  wrqs_pkg::wt_t   wts_d [wrqs_pkg::DEPTH];
  wrqs_pkg::cnt_t  cnt_q, cnt_d;

  wrqs_pkg::status_e res_status_q, res_status_d;
  wrqs_pkg::id_t     res_id_q, res_id_d;
  wrqs_pkg::wt_t     res_wt_q, res_wt_d;
  wrqs_pkg::count_t  res_count_q, res_count_d;
  logic              res_load;

  assign stat_o.count_lt2 = (cnt_q < wrqs_pkg::cnt_t'(2));

  // Update the entry list and build the result
  always_comb begin
    ids_d        = ids_q;
    wts_d        = wts_q;
    cnt_d        = cnt_q;
    res_status_d = wrqs_pkg::ST_OK;
    res_id_d     = '0;
    res_wt_d     = '0;
    res_load     = cmd_i.exec || cmd_i.sort_done;

    if (cmd_i.exec) begin
      case (operation_i)
        wrqs_pkg::OP_ENQUEUE: begin
          if (cnt_q == wrqs_pkg::CNT_FULL) begin
            res_status_d = wrqs_pkg::ST_FULL;
          end else begin
            // Shift toward the back, insert at the front
            for (int i = 1; i < wrqs_pkg::DEPTH; i++) begin
              ids_d[i] = ids_q[i-1];
              wts_d[i] = wts_q[i-1];
            end
            ids_d[0] = thread_id_i;
            wts_d[0] = weight_i;
            cnt_d    = cnt_q + 1'b1;
          end
        end
        wrqs_pkg::OP_DEQUEUE: begin
          if (cnt_q == '0) begin
            res_status_d = wrqs_pkg::ST_EMPTY;
          end else begin
            // Return the front and advance the rest
            res_id_d = ids_q[0];
            res_wt_d = wts_q[0];
            for (int i = 1; i < wrqs_pkg::DEPTH; i++) begin
              ids_d[i-1] = ids_q[i];
              wts_d[i-1] = wts_q[i];
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
        default: begin
          res_status_d = wrqs_pkg::ST_OK;
        end
      endcase
    end

    // One transposition pass: swap held neighbors only when strictly out
    // of order, so equal weights never cross
    if (cmd_i.pass_en) begin
      for (int j = 0; j < wrqs_pkg::DEPTH - 1; j++) begin
        if ((j[0] == cmd_i.pass_odd) &&
            (wrqs_pkg::cnt_t'(j + 1) < cnt_q) &&
            (wts_q[j] > wts_q[j+1])) begin
          ids_d[j]   = ids_q[j+1];
          wts_d[j]   = wts_q[j+1];
          ids_d[j+1] = ids_q[j];
          wts_d[j+1] = wts_q[j];
        end
      end
    end

    res_count_d = wrqs_pkg::count_t'(cnt_d);
  end

  // Entries and result payload
  always_ff @(posedge clk_i) begin
    ids_q <= ids_d;
    wts_q <= wts_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_wt_q     <= res_wt_d;
      res_count_q  <= res_count_d;
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign status_o        = res_status_q;
  assign out_thread_id_o = res_id_q;
  assign out_weight_o    = res_wt_q;
  assign count_o         = res_count_q;

endmodule

// ----- hw/rtl/weighted_run_queue_sort_core.sv -----
// ----------------------------------------------------------------------------
// Weighted run queue sort core
// Run queue of thread ids and Q4.12 weights with front enqueue, front
// dequeue and a stable sort by ascending weight.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i/in_ready_o  | operation, thread_id, weight
//   out     | output    | out_valid_o/out_ready_i| status, out_thread_id,
//           |           |                        | out_weight, count
//
// Enqueue, dequeue and unused codes: result in the cycle after the request.
// Sort: DEPTH transposition passes of the compare-swap network, one per
// cycle, with the result loaded together with the last pass (in the cycle
// after the request when fewer than two entries are held).
// A new request is taken when idle and the result register is free or is
// being drained in the same cycle; a stalled result holds the next request.
// Reset clears the entry count and control; entries hold no reset value.
// ----------------------------------------------------------------------------
module weighted_run_queue_sort_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  thread_id_i,
  input  logic [15:0] weight_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_thread_id_o,
  output logic [15:0] out_weight_o,
  output logic [4:0]  count_o
);

  wrqs_pkg::cmd_t  cmd;
  wrqs_pkg::stat_t stat;

  // Request sequencing
  wrqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Entry storage and result
  wrqs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .thread_id_i     (thread_id_i),
    .weight_i        (weight_i),
    .status_o        (status_o),
    .out_thread_id_o (out_thread_id_o),
    .out_weight_o    (out_weight_o),
    .count_o         (count_o)
  );

endmodule

// ----- hw/rtl/wrqs_chk.sv -----
// ----------------------------------------------------------------------------
// Weighted run queue sort: port checker
// Checks results seen on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "weighted_run_queue_sort_core_defines.svh"

module wrqs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [7:0]  out_thread_id_i,
  input logic [15:0] out_weight_i,
  input logic [4:0]  count_i
);

  // Held count never exceeds the queue depth
  `WRQS_ASSERT_IMP(a_count_max, clk_i, rst_ni, out_valid_i, count_i <= wrqs_pkg::DEPTH)

  // Dropped enqueue returns no entry
  `WRQS_ASSERT_IMP(a_full_zero, clk_i, rst_ni, out_valid_i && (status_i == wrqs_pkg::ST_FULL), (out_thread_id_i == '0) && (out_weight_i == '0))

  // Dequeue on empty reports an empty queue and no entry
  `WRQS_ASSERT_IMP(a_empty_cnt, clk_i, rst_ni, out_valid_i && (status_i == wrqs_pkg::ST_EMPTY), (count_i == '0) && (out_thread_id_i == '0) && (out_weight_i == '0))

  // Stalled result holds
  `WRQS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(out_thread_id_i) && $stable(out_weight_i) && $stable(count_i))

endmodule

bind weighted_run_queue_sort_core wrqs_chk u_wrqs_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_i        (status_o),
  .out_thread_id_i (out_thread_id_o),
  .out_weight_i    (out_weight_o),
  .count_i         (count_o)
);
